/* sv/sgm_pkg.sv */
`default_nettype none
package sgm_pkg;

    localparam int CORDIC_STEPS = 56;
    localparam int SQRT_STEPS   = 12;

    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
    localparam logic [63:0] PI_Q48 = 64'h0003243F6A8885A3;
    localparam logic [63:0] DIV_D  = 64'h0006487ED5110B46;

    localparam logic signed [14:0] ANG_0   = 15'sd0;
    localparam logic signed [14:0] ANG_45  = 15'sd2880;
    localparam logic signed [14:0] ANG_90  = 15'sd5760;
    localparam logic signed [14:0] ANG_180 = 15'sd11520;

    typedef logic [63:0] atan_tab_t [CORDIC_STEPS];

    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_CALC,
        S_PUT
    } top_state_t;

    typedef enum logic [2:0] {
        E_IDLE,
        E_PREP,
        E_INIT,
        E_ITER,
        E_SCALE,
        E_DIV,
        E_MUL,
        E_DONE
    } eng_state_t;

    // restoring long division, used at elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], n[b]};
            if (rem >= {1'b0, d})
            begin
                rem = rem - {1'b0, d};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // atan(2^-i) in radians, Q62, by the alternating series
    function automatic atan_tab_t build_atan_tab();
        atan_tab_t tab;
        logic [63:0] acc;
        logic [63:0] term;
        int e;
        tab[0] = PI_Q60;
        for (int i = 1; i < CORDIC_STEPS; i++)
        begin
            acc = '0;
            for (int k = 0; k < 32; k++)
            begin
                e = 62 - i * (2 * k + 1);
                if (e >= 0)
                begin
                    term = udiv64(64'd1 << e, 64'(2 * k + 1));
                    if (k % 2 == 1)
                        acc = acc - term;
                    else
                        acc = acc + term;
                end
            end
            tab[i] = acc;
        end
        return tab;
    endfunction

    // floor(2^63 / DIV_D), reciprocal for the degree scaling
    localparam logic [63:0] DIV_RECIP = udiv64(64'h8000000000000000, DIV_D);

endpackage
`default_nettype wire

/* sv/sgm_ram.sv */
`default_nettype none
module sgm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

/* sv/sgm_engine.sv */
`default_nettype none
module sgm_engine (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [10:0] sx,
    input  wire logic signed [10:0] sy,
    output logic                    done,
    output logic [11:0]             magnitude,
    output logic signed [14:0]      angle
);

    localparam sgm_pkg::atan_tab_t ATAN_TAB = sgm_pkg::build_atan_tab();
    localparam logic [12:0] RECIP  = sgm_pkg::DIV_RECIP[12:0];
    localparam logic [50:0] DIV_LO = sgm_pkg::DIV_D[50:0];

    sgm_pkg::eng_state_t state_reg, state_next;

    logic [5:0]          step_reg, step_next;
    logic signed [10:0]  sx_reg, sx_next, sy_reg, sy_next;
    logic [9:0]          ax_reg, ax_next, ay_reg, ay_next;
    logic [19:0]         sqx_reg, sqx_next, sqy_reg, sqy_next;
    logic [23:0]         rem_reg, rem_next, root_reg, root_next, bit_reg, bit_next;
    logic signed [63:0]  x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic [63:0]         num_reg, num_next;
    logic [11:0]         quo_reg, quo_next;
    logic [11:0]         mag_reg, mag_next;
    logic signed [14:0]  ang_reg, ang_next;

    logic [23:0]         rb;
    logic signed [63:0]  x_sh, y_sh;
    logic [47:0]         zq;
    logic [63:0]         prod;
    logic [38:0]         est_p;
    logic [62:0]         qd;
    logic [9:0]          big, small_v;
    logic signed [14:0]  a_oct, a_fold;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sgm_pkg::E_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        sx_reg   <= sx_next;
        sy_reg   <= sy_next;
        ax_reg   <= ax_next;
        ay_reg   <= ay_next;
        sqx_reg  <= sqx_next;
        sqy_reg  <= sqy_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        num_reg  <= num_next;
        quo_reg  <= quo_next;
        mag_reg  <= mag_next;
        ang_reg  <= ang_next;
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        sx_next    = sx_reg;
        sy_next    = sy_reg;
        ax_next    = ax_reg;
        ay_next    = ay_reg;
        sqx_next   = sqx_reg;
        sqy_next   = sqy_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        bit_next   = bit_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        num_next   = num_reg;
        quo_next   = quo_reg;
        mag_next   = mag_reg;
        ang_next   = ang_reg;
        done       = 1'b0;

        big     = (ay_reg < ax_reg) ? ax_reg : ay_reg;
        small_v = (ay_reg < ax_reg) ? ay_reg : ax_reg;
        rb      = root_reg + bit_reg;
        // truncate toward zero, as a signed divide by 2^i does
        x_sh    = x_reg[63] ? -((-x_reg) >>> step_reg) : (x_reg >>> step_reg);
        y_sh    = y_reg[63] ? -((-y_reg) >>> step_reg) : (y_reg >>> step_reg);
        zq      = z_reg[61:14];
        // zq * 11520 as shifts and adds
        prod    = ({16'd0, zq} << 13) + ({16'd0, zq} << 11)
                + ({16'd0, zq} << 10) + ({16'd0, zq} << 8);
        // quotient estimate from the top bits, low by at most one
        est_p   = {13'd0, num_reg[63:38]} * {26'd0, RECIP};
        qd      = {51'd0, quo_reg} * {12'd0, DIV_LO};
        a_oct   = 15'(signed'({1'b0, quo_reg}))
                + ((num_reg >= sgm_pkg::DIV_D) ? 15'sd1 : 15'sd0);
        a_fold  = ANG_FOLD(ax_reg, ay_reg, a_oct);

        unique case (state_reg)
            sgm_pkg::E_IDLE:
            begin
                if (start)
                begin
                    sx_next    = sx;
                    sy_next    = sy;
                    state_next = sgm_pkg::E_PREP;
                end
            end
            sgm_pkg::E_PREP:
            begin
                ax_next    = 10'(sx_reg[10] ? -sx_reg : sx_reg);
                ay_next    = 10'(sy_reg[10] ? -sy_reg : sy_reg);
                sqx_next   = 20'(sx_reg * sx_reg);
                sqy_next   = 20'(sy_reg * sy_reg);
                state_next = sgm_pkg::E_INIT;
            end
            sgm_pkg::E_INIT:
            begin
                rem_next   = {2'b00, ({1'b0, sqx_reg} + {1'b0, sqy_reg}), 1'b0} << 1;
                root_next  = '0;
                bit_next   = 24'd1 << 22;
                x_next     = signed'({6'd0, big, 48'd0});
                y_next     = signed'({6'd0, small_v, 48'd0});
                z_next     = '0;
                step_next  = '0;
                state_next = sgm_pkg::E_ITER;
            end
            sgm_pkg::E_ITER:
            begin
                if (step_reg < 6'(sgm_pkg::SQRT_STEPS))
                begin
                    if (rem_reg >= rb)
                    begin
                        rem_next  = rem_reg - rb;
                        root_next = (root_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        root_next = root_reg >> 1;
                    end
                    bit_next = bit_reg >> 2;
                end
                if (!y_reg[63])
                begin
                    x_next = x_reg + y_sh;
                    y_next = y_reg - x_sh;
                    z_next = z_reg + signed'(ATAN_TAB[step_reg]);
                end
                else
                begin
                    x_next = x_reg - y_sh;
                    y_next = y_reg + x_sh;
                    z_next = z_reg - signed'(ATAN_TAB[step_reg]);
                end
                if (step_reg == 6'(sgm_pkg::CORDIC_STEPS - 1))
                begin
                    state_next = sgm_pkg::E_SCALE;
                end
                step_next = step_reg + 6'd1;
            end
            sgm_pkg::E_SCALE:
            begin
                if (z_reg[63])
                begin
                    z_next = '0;
                end
                else
                begin
                    num_next   = (prod << 1) + sgm_pkg::PI_Q48;
                    quo_next   = '0;
                    step_next  = '0;
                    state_next = sgm_pkg::E_DIV;
                end
            end
            sgm_pkg::E_DIV:
            begin
                quo_next   = est_p[36:25];
                state_next = sgm_pkg::E_MUL;
            end
            sgm_pkg::E_MUL:
            begin
                // remainder of the estimate, below twice the divisor
                num_next   = num_reg - {1'b0, qd};
                state_next = sgm_pkg::E_DONE;
            end
            sgm_pkg::E_DONE:
            begin
                mag_next = 12'(root_reg) + ((rem_reg > root_reg) ? 12'd1 : 12'd0);
                if (sx_reg[10])
                    ang_next = sgm_pkg::ANG_180 - a_fold;
                else
                    ang_next = a_fold;
                if (sy_reg[10])
                    ang_next = -((sx_reg[10]) ? (sgm_pkg::ANG_180 - a_fold) : a_fold);
                done       = 1'b1;
                state_next = sgm_pkg::E_IDLE;
            end
            default:
            begin
                state_next = sgm_pkg::E_IDLE;
            end
        endcase
    end

    // first-quadrant angle from magnitudes and the octant result
    function automatic logic signed [14:0] ANG_FOLD(input logic [9:0] ax,
                                                    input logic [9:0] ay,
                                                    input logic signed [14:0] oct);
        logic signed [14:0] a;
        if (ay == 10'd0)
            a = sgm_pkg::ANG_0;
        else if (ax == 10'd0)
            a = sgm_pkg::ANG_90;
        else if (ax == ay)
            a = sgm_pkg::ANG_45;
        else if (ay < ax)
            a = oct;
        else
            a = sgm_pkg::ANG_90 - oct;
        return a;
    endfunction

    assign magnitude = mag_reg;
    assign angle     = ang_reg;

endmodule
`default_nettype wire

/* sv/sobel_gradient_magnitude_angle.sv */
`default_nettype none
// Streaming 3x3 Sobel gradient, magnitude and direction.
//
// Input channel: in_valid/in_ready with pixel_value, one 8-bit grayscale
// pixel per request, raster order. Output channel: out_valid/out_ready with
// magnitude (Q.1), angle (degrees, Q.6 signed) and the window's top-left
// out_col/out_row. A pixel in column < 2 or row < 2 yields no result.
// Configuration: cfg_we with cfg_index (0 width, 1 height) and cfg_data,
// written only while idle by the user, as the block does not enforce it;
// values are clamped to the legal range.
//
// A pixel with no result is accepted, then the line store read-modify-write
// follows. A pixel with a result also runs the gradient engine: 56 CORDIC
// steps at one per cycle (the 12-step square root runs alongside), then a
// reciprocal multiply and a one-step correction for the degree scaling; a
// CORDIC angle ending below zero is first cleared to zero. No new pixel
// is taken before the last result reaches the output register, which holds
// one result, so the next pixel is taken while a result waits; a stalled
// receiver only holds the block once the engine has a second result ready.
// Reset clears counters, window and control state; the line stores need
// no clearing pass: unwritten entries are never read in a fixed-size frame.
module sobel_gradient_magnitude_angle #(
    parameter int MAX_WIDTH = 2048
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic                           cfg_index,
    input  wire logic [12:0]                    cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [7:0]                     pixel_value,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [11:0]                         magnitude,
    output logic signed [14:0]                  angle,
    output logic [$clog2(MAX_WIDTH)-1:0]        out_col,
    output logic [11:0]                         out_row
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = ($clog2(MAX_WIDTH + 1) > 12) ? $clog2(MAX_WIDTH + 1) : 12;

    sgm_pkg::top_state_t state_reg, state_next;

    // configuration and frame position
    logic [11:0]    width_reg;
    logic [12:0]    height_reg;
    logic [CW-1:0]  col_reg, col_next;
    logic [11:0]    row_reg, row_next;

    // current request
    logic [7:0]     pix_reg;
    logic [CW-1:0]  ccol_reg;
    logic [11:0]    crow_reg;

    // two previous columns of the window rows
    logic [7:0]     win_reg [6];

    logic [CW-1:0]      tcol_reg;
    logic [11:0]        trow_reg;

    logic               ovalid_reg;
    logic [11:0]        omag_reg;
    logic signed [14:0] oang_reg;
    logic [CW-1:0]      ocol_reg;
    logic [11:0]        orow_reg;

    logic [WW-1:0]  w_eff;
    logic [12:0]    h_eff;
    logic [CW-1:0]  col_eff;
    logic [11:0]    row_eff;
    logic [7:0]     older_q, newer_q;
    logic           accept, emit, eng_start, eng_done;
    logic [11:0]    eng_mag;
    logic signed [14:0] eng_ang;
    logic signed [11:0] gx, gy;
    logic signed [10:0] eng_sx, eng_sy;

    // clamp the frame size
    always_comb
    begin
        if (WW'(width_reg) < WW'(3))
            w_eff = WW'(3);
        else if (WW'(width_reg) > WW'(MAX_WIDTH))
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(width_reg);
        if (height_reg < 13'd3)
            h_eff = 13'd3;
        else if (height_reg > 13'd4096)
            h_eff = 13'd4096;
        else
            h_eff = height_reg;
    end

    // restart a counter left beyond a smaller frame
    assign col_eff = (WW'(col_reg) >= w_eff) ? '0 : col_reg;
    assign row_eff = ({1'b0, row_reg} >= h_eff) ? 12'd0 : row_reg;

    assign in_ready = (state_reg == sgm_pkg::S_IDLE);
    assign accept   = in_valid && in_ready;
    assign emit     = (ccol_reg >= CW'(2)) && (crow_reg >= 12'd2);

    // line stores: read at accept, write back in the following cycle
    sgm_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_older (
        .clk   (clk),
        .we    (state_reg == sgm_pkg::S_LOAD),
        .waddr (ccol_reg),
        .wdata (newer_q),
        .raddr (col_eff),
        .rdata (older_q)
    );

    sgm_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_newer (
        .clk   (clk),
        .we    (state_reg == sgm_pkg::S_LOAD),
        .waddr (ccol_reg),
        .wdata (pix_reg),
        .raddr (col_eff),
        .rdata (newer_q)
    );

    // Sobel sums from window, store outputs and the new pixel
    always_comb
    begin
        gx = (12'(older_q) + (12'(newer_q) << 1) + 12'(pix_reg))
           - (12'(win_reg[0]) + (12'(win_reg[2]) << 1) + 12'(win_reg[4]));
        gy = (12'(win_reg[4]) + (12'(win_reg[5]) << 1) + 12'(pix_reg))
           - (12'(win_reg[0]) + (12'(win_reg[1]) << 1) + 12'(older_q));
    end

    // hand the sums straight to the engine, which latches them on start
    assign eng_sx = 11'(gx);
    assign eng_sy = 11'(gy);

    // frame counters advance after each pixel
    always_comb
    begin
        if (WW'(ccol_reg) + WW'(1) >= w_eff)
        begin
            col_next = '0;
            row_next = ({1'b0, crow_reg} + 13'd1 >= h_eff) ? 12'd0 : crow_reg + 12'd1;
        end
        else
        begin
            col_next = ccol_reg + CW'(1);
            row_next = crow_reg;
        end
    end

    assign eng_start = (state_reg == sgm_pkg::S_LOAD) && emit;

    sgm_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (eng_start),
        .sx        (eng_sx),
        .sy        (eng_sy),
        .done      (eng_done),
        .magnitude (eng_mag),
        .angle     (eng_ang)
    );

    // control: accept, update stores, wait for the engine, hand over
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sgm_pkg::S_IDLE:
            begin
                if (accept)
                    state_next = sgm_pkg::S_LOAD;
            end
            sgm_pkg::S_LOAD:
            begin
                state_next = emit ? sgm_pkg::S_CALC : sgm_pkg::S_IDLE;
            end
            sgm_pkg::S_CALC:
            begin
                if (eng_done)
                    state_next = sgm_pkg::S_PUT;
            end
            sgm_pkg::S_PUT:
            begin
                if (!ovalid_reg || out_ready)
                    state_next = sgm_pkg::S_IDLE;
            end
            default:
            begin
                state_next = sgm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= sgm_pkg::S_IDLE;
            width_reg  <= 12'd640;
            height_reg <= 13'd480;
            col_reg    <= '0;
            row_reg    <= '0;
            ovalid_reg <= 1'b0;
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    sgm_pkg::REG_WIDTH:  width_reg  <= cfg_data[11:0];
                    sgm_pkg::REG_HEIGHT: height_reg <= cfg_data;
                    default:             ;
                endcase
            end
            if (state_reg == sgm_pkg::S_LOAD)
            begin
                // shift the window left by one column
                win_reg[0] <= win_reg[1];
                win_reg[1] <= older_q;
                win_reg[2] <= win_reg[3];
                win_reg[3] <= newer_q;
                win_reg[4] <= win_reg[5];
                win_reg[5] <= pix_reg;
                col_reg    <= col_next;
                row_reg    <= row_next;
            end
            if (state_reg == sgm_pkg::S_PUT && (!ovalid_reg || out_ready))
                ovalid_reg <= 1'b1;
            else if (out_ready)
                ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix_reg  <= pixel_value;
            ccol_reg <= col_eff;
            crow_reg <= row_eff;
        end
        if (state_reg == sgm_pkg::S_LOAD)
        begin
            tcol_reg <= ccol_reg - CW'(2);
            trow_reg <= crow_reg - 12'd2;
        end
        if (state_reg == sgm_pkg::S_PUT && (!ovalid_reg || out_ready))
        begin
            omag_reg <= eng_mag;
            oang_reg <= eng_ang;
            ocol_reg <= tcol_reg;
            orow_reg <= trow_reg;
        end
    end

    assign out_valid = ovalid_reg;
    assign magnitude = omag_reg;
    assign angle     = oang_reg;
    assign out_col   = ocol_reg;
    assign out_row   = orow_reg;

endmodule
`default_nettype wire

/* bench/tb.sv */
module tb;

    typedef struct {
        logic [11:0]        mag;
        logic signed [14:0] ang;
        logic [10:0]        col;
        logic [11:0]        row;
    } gradient_t;

    // Gradient predictor: tracks the window, line stores and raster position,
    // and holds the gradients still owed by the block.
    class gradient_board;
        longint unsigned atan_q62[sgm_pkg::CORDIC_STEPS];
        byte unsigned    older_line[2048];
        byte unsigned    newer_line[2048];
        byte unsigned    win[6];
        int              col_cnt;
        int              row_cnt;
        int              width_reg;
        int              height_reg;
        gradient_t       owed[$];
        int              errors;

        function new();
            longint unsigned acc;
            longint unsigned term;
            int e;
            atan_q62[0] = sgm_pkg::PI_Q60;
            for (int i = 1; i < sgm_pkg::CORDIC_STEPS; i++)
            begin
                acc = 0;
                for (int k = 0; k < 64; k++)
                begin
                    e = 62 - i * (2 * k + 1);
                    if (e < 0)
                        break;
                    term = (64'd1 << e) / longint'(2 * k + 1);
                    if (k % 2 == 1)
                        acc = acc - term;
                    else
                        acc = acc + term;
                end
                atan_q62[i] = acc;
            end
            foreach (older_line[i])
            begin
                older_line[i] = 0;
                newer_line[i] = 0;
            end
            foreach (win[i])
                win[i] = 0;
            col_cnt = 0;
            row_cnt = 0;
            width_reg = 640;
            height_reg = 480;
            errors = 0;
        endfunction

        function int eff_width();
            return width_reg < 3 ? 3 : (width_reg > 2048 ? 2048 : width_reg);
        endfunction

        function int eff_height();
            return height_reg < 3 ? 3 : (height_reg > 4096 ? 4096 : height_reg);
        endfunction

        function bit at_frame_start();
            return (col_cnt == 0 || col_cnt >= eff_width())
                && (row_cnt == 0 || row_cnt >= eff_height());
        endfunction

        function void set_reg(sgm_pkg::reg_index_t idx, int val);
            if (idx == sgm_pkg::REG_WIDTH)
                width_reg = val & 'hFFF;
            else
                height_reg = val & 'h1FFF;
        endfunction

        // first octant, 0 < ay < ax; returns 64 * degrees, rounded
        function int octant_deg(int ax, int ay);
            longint x, y, z, nx, d;
            longint unsigned zq, num;
            x = longint'(ax) <<< 48;
            y = longint'(ay) <<< 48;
            z = 0;
            for (int i = 0; i < sgm_pkg::CORDIC_STEPS; i++)
            begin
                d = longint'(1) <<< i;
                if (y >= 0)
                begin
                    nx = x + y / d;
                    y = y - x / d;
                    z = z + longint'(atan_q62[i]);
                end
                else
                begin
                    nx = x - y / d;
                    y = y + x / d;
                    z = z - longint'(atan_q62[i]);
                end
                x = nx;
            end
            if (z < 0)
                z = 0;
            zq = longint'(z) >> 14;
            num = zq * 64'd11520;
            return int'((64'd2 * num + sgm_pkg::PI_Q48) / (64'd2 * sgm_pkg::PI_Q48));
        endfunction

        function void note_pixel(byte unsigned pix);
            int w, h, c, r, sx, sy, ax, ay, a, q, m, rem_q, bitv;
            int p[3][3];
            gradient_t g;
            w = eff_width();
            h = eff_height();
            c = col_cnt >= w ? 0 : col_cnt;
            r = row_cnt >= h ? 0 : row_cnt;
            for (int i = 0; i < 3; i++)
            begin
                p[i][0] = win[i * 2];
                p[i][1] = win[i * 2 + 1];
            end
            p[0][2] = older_line[c];
            p[1][2] = newer_line[c];
            p[2][2] = pix;
            if (c >= 2 && r >= 2)
            begin
                sx = (p[0][2] + 2 * p[1][2] + p[2][2]) - (p[0][0] + 2 * p[1][0] + p[2][0]);
                sy = (p[2][0] + 2 * p[2][1] + p[2][2]) - (p[0][0] + 2 * p[0][1] + p[0][2]);
                // integer square root, rounded to nearest
                q = 4 * (sx * sx + sy * sy);
                rem_q = q;
                m = 0;
                bitv = 1 << 30;
                while (bitv > rem_q)
                    bitv = bitv >> 2;
                while (bitv != 0)
                begin
                    if (rem_q >= m + bitv)
                    begin
                        rem_q = rem_q - (m + bitv);
                        m = (m >> 1) + bitv;
                    end
                    else
                        m = m >> 1;
                    bitv = bitv >> 2;
                end
                if (q - m * m > m)
                    m++;
                ax = sx < 0 ? -sx : sx;
                ay = sy < 0 ? -sy : sy;
                if (ax == 0 && ay == 0)
                    a = 0;
                else
                begin
                    if (ay == 0)
                        a = 0;
                    else if (ax == 0)
                        a = 5760;
                    else if (ax == ay)
                        a = 2880;
                    else if (ay < ax)
                        a = octant_deg(ax, ay);
                    else
                        a = 5760 - octant_deg(ay, ax);
                    if (sx < 0)
                        a = 11520 - a;
                    if (sy < 0)
                        a = -a;
                end
                g.mag = m[11:0];
                g.ang = a[14:0];
                g.col = 11'(c - 2);
                g.row = 12'(r - 2);
                owed.push_back(g);
            end
            older_line[c] = p[1][2];
            newer_line[c] = p[2][2];
            for (int i = 0; i < 3; i++)
            begin
                win[i * 2] = p[i][1];
                win[i * 2 + 1] = p[i][2];
            end
            if (c + 1 >= w)
            begin
                c = 0;
                r = (r + 1 >= h) ? 0 : r + 1;
            end
            else
                c++;
            col_cnt = c;
            row_cnt = r;
        endfunction

        function void check_result(gradient_t got);
            gradient_t want;
            if (owed.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected gradient: mag %0d ang %0d col %0d row %0d",
                             got.mag, got.ang, got.col, got.row);
                return;
            end
            want = owed.pop_front();
            if (got.mag !== want.mag || got.ang !== want.ang
                || got.col !== want.col || got.row !== want.row)
            begin
                errors++;
                if (errors <= 10)
                    $display("gradient mismatch: exp mag %0d ang %0d col %0d row %0d, got mag %0d ang %0d col %0d row %0d",
                             want.mag, want.ang, want.col, want.row,
                             got.mag, got.ang, got.col, got.row);
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic               cfg_index;
    logic [12:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [7:0]         pixel_value;
    logic               out_valid;
    logic               out_ready;
    logic [11:0]        magnitude;
    logic signed [14:0] angle;
    logic [10:0]        out_col;
    logic [11:0]        out_row;

    gradient_board board;
    int            burst_left;
    int            hold_request;
    int            random_sent;
    int            frame_mode;
    byte unsigned  flat_level;

    sobel_gradient_magnitude_angle dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pixel_value (pixel_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .magnitude   (magnitude),
        .angle       (angle),
        .out_col     (out_col),
        .out_row     (out_row)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one pixel request and hold it until the block takes it. Bursts of
    // random length are separated by random gaps with valid dropped.
    task automatic send_pixel(input byte unsigned pix);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        in_valid <= 1'b1;
        pixel_value <= pix;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_pixel(pix);
        burst_left--;
    endtask

    // Let the pipeline drain fully so that a register write lands while idle.
    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        while (board.owed.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_reg(input sgm_pkg::reg_index_t idx, input int val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= 13'(val);
        @(posedge clk);
        cfg_we <= 1'b0;
        board.set_reg(idx, val);
    endtask

    function automatic byte unsigned pick_pixel();
        case (frame_mode)
            0: return 8'($urandom_range(0, 255));
            1: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
            2: return $urandom_range(0, 7) == 0 ? 8'($urandom) : flat_level;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Advance with random pixels until the raster position is back at the
    // top-left corner, so that a larger size never reads stale store entries.
    task automatic finish_frame();
        while (!board.at_frame_start())
            send_pixel(pick_pixel());
    endtask

    task automatic send_frame3(input byte unsigned img[9]);
        foreach (img[i])
            send_pixel(img[i]);
    endtask

    // Receiver: check every result taken, and stall on a pattern of its own:
    // stretches of heavy random back-pressure alternate with stall-free ones,
    // plus one long hold-off on request.
    initial
    begin
        int cyc;
        int hold_left;
        gradient_t got;
        cyc = 0;
        hold_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                got.mag = magnitude;
                got.ang = angle;
                got.col = out_col;
                got.row = out_row;
                board.check_result(got);
            end
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            cyc++;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if ((cyc / 300) % 3 == 1)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    initial
    begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        byte unsigned img[9];
        int w, h, n;
        board = new();
        burst_left = 0;
        hold_request = 0;
        random_sent = 0;
        frame_mode = 0;
        flat_level = 0;
        cfg_we = 1'b0;
        cfg_index = sgm_pkg::REG_WIDTH;
        cfg_data = '0;
        in_valid = 1'b0;
        pixel_value = '0;
        out_ready = 1'b0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: smallest frame, one window each
        write_reg(sgm_pkg::REG_WIDTH, 3);
        write_reg(sgm_pkg::REG_HEIGHT, 3);
        img = '{0, 0, 0, 0, 0, 0, 0, 0, 0};           // flat: no gradient, angle zero
        send_frame3(img);
        img = '{255, 255, 0, 255, 255, 0, 255, 255, 0}; // gy zero, gx negative
        send_frame3(img);
        img = '{0, 0, 0, 0, 0, 0, 255, 255, 255};     // gx zero, gy positive
        send_frame3(img);
        img = '{0, 0, 255, 0, 0, 255, 255, 255, 255}; // diagonal, equal gradients
        send_frame3(img);
        img = '{255, 0, 0, 255, 0, 0, 255, 255, 0};   // mixed signs
        send_frame3(img);
        drain();

        // register below range clamps to the minimum
        write_reg(sgm_pkg::REG_WIDTH, 0);
        write_reg(sgm_pkg::REG_HEIGHT, 1);
        frame_mode = 1;
        repeat (9) send_pixel(pick_pixel());
        drain();

        // width above range clamps to the widest row, then shrinks mid-row
        write_reg(sgm_pkg::REG_WIDTH, 4095);
        write_reg(sgm_pkg::REG_HEIGHT, 3);
        frame_mode = 0;
        repeat (100) send_pixel(pick_pixel());
        drain();
        write_reg(sgm_pkg::REG_WIDTH, 5);
        finish_frame();
        drain();

        // tallest frame entered partly, then height shrunk mid-frame
        write_reg(sgm_pkg::REG_WIDTH, 3);
        write_reg(sgm_pkg::REG_HEIGHT, 8191);
        repeat (3 * 20 + 1) send_pixel(pick_pixel());
        drain();
        write_reg(sgm_pkg::REG_HEIGHT, 5);
        finish_frame();
        drain();

        // width shrunk mid-frame
        write_reg(sgm_pkg::REG_WIDTH, 10);
        write_reg(sgm_pkg::REG_HEIGHT, 6);
        repeat (25) send_pixel(pick_pixel());
        drain();
        write_reg(sgm_pkg::REG_WIDTH, 5);
        finish_frame();
        drain();

        // random phases: small frames with varied content
        n = 0;
        while (random_sent < 250)
        begin
            w = $urandom_range(0, 12);
            h = $urandom_range(0, 6);
            write_reg(sgm_pkg::REG_WIDTH, w);
            write_reg(sgm_pkg::REG_HEIGHT, h);
            frame_mode = $urandom_range(0, 2);
            flat_level = 8'($urandom);
            if (n == 2)
                hold_request = 2000;
            repeat ($urandom_range(1, 3) * board.eff_width() * board.eff_height())
            begin
                send_pixel(pick_pixel());
                random_sent++;
            end
            finish_frame();
            drain();
            n++;
        end

        drain();
        if (board.owed.size() != 0)
            board.errors += board.owed.size();
        if (board.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
